/* rtl/yuv_plane_ssd_accumulator_assert.svh */
// ----------------------------------------------------------------------------
// yuv_plane_ssd_accumulator_assert.svh
// Assertion macros shared by the plane SSD accumulator modules. Each macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef YUV_PLANE_SSD_ACCUMULATOR_ASSERT_SVH
`define YUV_PLANE_SSD_ACCUMULATOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define YUVSSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define YUVSSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/yuvssd_pkg.sv */
// ----------------------------------------------------------------------------
// yuvssd_pkg
// Shared types and constants for the per-plane SSD accumulator.
// ----------------------------------------------------------------------------
package yuvssd_pkg;

    // Configuration register port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MODE  = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

    // Chroma subsampling modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] YUV420 = 2'd0;
    localparam logic [MODE_W-1:0] YUV422 = 2'd1;
    localparam logic [MODE_W-1:0] YUV444 = 2'd2;

    // Plane codes
    localparam int PLANE_W = 2;
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // Sum width
    localparam int SSD_W = 45;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int MAX_HEIGHT_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 10;

    // Per-word control that travels with each difference
    typedef struct packed {
        logic               last;
        logic [PLANE_W-1:0] plane;
    } item_ctrl_t;

endpackage

/* rtl/yuvssd_front.sv */
// ----------------------------------------------------------------------------
// yuvssd_front
// Holds the configuration, tracks raster position per plane, forms the
// absolute sample difference and tags each word with plane and last-of-plane.
// ----------------------------------------------------------------------------
`include "yuv_plane_ssd_accumulator_assert.svh"

module yuvssd_front #(
    parameter int MAX_WIDTH   = yuvssd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = yuvssd_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = yuvssd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [yuvssd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yuvssd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  logic [SAMPLE_BITS-1:0]          ref_sample,
    input  logic [SAMPLE_BITS-1:0]          test_sample,
    output logic                            q_push,
    output logic [SAMPLE_BITS-1:0]          q_diff,
    output yuvssd_pkg::item_ctrl_t          q_ctrl,
    input  logic                            q_full
);

    localparam int CNT_X_W = $clog2(MAX_WIDTH);
    localparam int CNT_Y_W = $clog2(MAX_HEIGHT);
    localparam int DIM_X_W = $clog2(MAX_WIDTH + 1);
    localparam int DIM_Y_W = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_X_W = (DIM_X_W > yuvssd_pkg::CFG_W) ? DIM_X_W : yuvssd_pkg::CFG_W;
    localparam int CMP_Y_W = (DIM_Y_W > yuvssd_pkg::CFG_W) ? DIM_Y_W : yuvssd_pkg::CFG_W;

    logic [yuvssd_pkg::CFG_W-1:0]   width_reg;
    logic [yuvssd_pkg::CFG_W-1:0]   height_reg;
    logic [yuvssd_pkg::MODE_W-1:0]  chroma_reg;
    logic [CNT_X_W-1:0]             col_reg;
    logic [CNT_Y_W-1:0]             row_reg;
    logic [yuvssd_pkg::PLANE_W-1:0] plane_reg;

    logic [CMP_X_W-1:0] w_clamp;
    logic [CMP_Y_W-1:0] h_clamp;
    logic [CMP_X_W-1:0] w_plane;
    logic [CMP_Y_W-1:0] h_plane;
    logic [CMP_X_W-1:0] pw;
    logic [CMP_Y_W-1:0] ph;
    logic [CNT_X_W-1:0] col_inc;
    logic [CNT_Y_W-1:0] row_inc;
    logic               row_end;
    logic               plane_end;
    logic               accept;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= yuvssd_pkg::FRAME_WIDTH_RST;
            height_reg <= yuvssd_pkg::FRAME_HEIGHT_RST;
            chroma_reg <= yuvssd_pkg::YUV420;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                yuvssd_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                yuvssd_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                yuvssd_pkg::REG_CHROMA_MODE:
                    chroma_reg <= cfg_data[yuvssd_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp luma size to the supported maximum
    always_comb
    begin
        w_clamp = CMP_X_W'(width_reg);
        h_clamp = CMP_Y_W'(height_reg);
        if (w_clamp > CMP_X_W'(MAX_WIDTH))
            w_clamp = CMP_X_W'(MAX_WIDTH);
        if (h_clamp > CMP_Y_W'(MAX_HEIGHT))
            h_clamp = CMP_Y_W'(MAX_HEIGHT);
    end

    // Derive the current plane size; unused mode code acts as 4:4:4
    always_comb
    begin
        w_plane = w_clamp;
        h_plane = h_clamp;
        if (plane_reg != yuvssd_pkg::PLANE_Y)
        begin
            unique case (chroma_reg)
                yuvssd_pkg::YUV420:
                begin
                    w_plane = w_clamp >> 1;
                    h_plane = h_clamp >> 1;
                end
                yuvssd_pkg::YUV422:
                begin
                    w_plane = w_clamp >> 1;
                end
                default: ;
            endcase
        end
        pw = (w_plane == '0) ? CMP_X_W'(1) : w_plane;
        ph = (h_plane == '0) ? CMP_Y_W'(1) : h_plane;
    end

    // Classify the position: end of row, end of plane
    assign accept    = sample_valid && sample_ready;
    assign col_inc   = col_reg + CNT_X_W'(1);
    assign row_inc   = row_reg + CNT_Y_W'(1);
    assign row_end   = (col_inc == '0) || (CMP_X_W'(col_inc) >= pw);
    assign plane_end = row_end && ((row_inc == '0) || (CMP_Y_W'(row_inc) >= ph));

    // Advance raster position on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= yuvssd_pkg::PLANE_Y;
        end
        else if (accept)
        begin
            col_reg <= row_end ? '0 : col_inc;
            if (plane_end)
            begin
                row_reg   <= '0;
                plane_reg <= (plane_reg == yuvssd_pkg::PLANE_V) ? yuvssd_pkg::PLANE_Y
                                                                : plane_reg + 2'd1;
            end
            else if (row_end)
            begin
                row_reg <= row_inc;
            end
        end
    end

    // Push the difference and its tag into the queue
    assign sample_ready  = !q_full;
    assign q_push        = accept;
    assign q_diff        = (ref_sample >= test_sample) ? (ref_sample - test_sample)
                                                       : (test_sample - ref_sample);
    assign q_ctrl.last   = plane_end;
    assign q_ctrl.plane  = plane_reg;

    `YUVSSD_ASSERT_NEXT(a_plane_wrap,
        accept && plane_end && (plane_reg == yuvssd_pkg::PLANE_V),
        plane_reg == yuvssd_pkg::PLANE_Y)
    `YUVSSD_ASSERT_NEXT(a_row_restart, accept && row_end, col_reg == '0)
    `YUVSSD_ASSERT_NEXT(a_hold_position, !accept,
        $stable(col_reg) && $stable(row_reg) && $stable(plane_reg))

endmodule

/* rtl/yuvssd_fifo.sv */
// ----------------------------------------------------------------------------
// yuvssd_fifo
// Short queue of tagged difference words between front and back.
// ----------------------------------------------------------------------------
module yuvssd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = yuvssd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

/* rtl/yuvssd_back.sv */
// ----------------------------------------------------------------------------
// yuvssd_back
// Squares each difference, accumulates per plane and holds the plane sum in
// an output register until the result word is taken.
// ----------------------------------------------------------------------------
`include "yuv_plane_ssd_accumulator_assert.svh"

module yuvssd_back #(
    parameter int SAMPLE_BITS = yuvssd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  logic [SAMPLE_BITS-1:0]           q_diff,
    input  yuvssd_pkg::item_ctrl_t           q_ctrl,
    output logic                             q_pop,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [yuvssd_pkg::PLANE_W-1:0]   plane,
    output logic [yuvssd_pkg::SSD_W-1:0]     plane_ssd,
    output logic                             frame_done
);

    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic                             s1_valid_reg;
    logic [SQ_W-1:0]                  s1_sq_reg;
    yuvssd_pkg::item_ctrl_t           s1_ctrl_reg;
    logic [yuvssd_pkg::SSD_W-1:0]     acc_reg;
    logic                             out_valid_reg;
    logic [yuvssd_pkg::PLANE_W-1:0]   out_plane_reg;
    logic [yuvssd_pkg::SSD_W-1:0]     out_ssd_reg;

    logic                             s1_stall;
    logic                             s1_fire;
    logic [yuvssd_pkg::SSD_W-1:0]     sum;

    // Only a last-of-plane word waits on a full output register
    assign s1_stall = s1_valid_reg && s1_ctrl_reg.last && out_valid_reg && !result_ready;
    assign s1_fire  = s1_valid_reg && !s1_stall;
    assign q_pop    = !q_empty && !s1_stall;
    assign sum      = acc_reg + yuvssd_pkg::SSD_W'(s1_sq_reg);

    // Square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (q_pop)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_sq_reg   <= SQ_W'(q_diff) * SQ_W'(q_diff);
            s1_ctrl_reg <= q_ctrl;
        end
    end

    // Accumulate; clear at the end of each plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (s1_fire)
            acc_reg <= s1_ctrl_reg.last ? '0 : sum;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_ctrl_reg.last)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctrl_reg.last)
        begin
            out_plane_reg <= s1_ctrl_reg.plane;
            out_ssd_reg   <= sum;
        end
    end

    assign result_valid = out_valid_reg;
    assign plane        = out_plane_reg;
    assign plane_ssd    = out_ssd_reg;
    assign frame_done   = (out_plane_reg == yuvssd_pkg::PLANE_V);

    `YUVSSD_ASSERT_NEXT(a_acc_clear, s1_fire && s1_ctrl_reg.last, acc_reg == '0)
    `YUVSSD_ASSERT_NEXT(a_result_load, s1_fire && s1_ctrl_reg.last,
        out_valid_reg && (out_ssd_reg == $past(sum)))
    `YUVSSD_ASSERT_SAME(a_done_on_v, result_valid,
        !frame_done || (plane == yuvssd_pkg::PLANE_V))

endmodule

/* rtl/yuv_plane_ssd_accumulator.sv */
// ----------------------------------------------------------------------------
// yuv_plane_ssd_accumulator
// Per-plane sum of squared differences over a Y, U, V raster stream.
//
//   channel   signals                                  direction
//   sample    sample_valid/ready, ref_sample,          in
//             test_sample
//   result    result_valid/ready, plane, plane_ssd,    out
//             frame_done
//   cfg       cfg_valid/ready, cfg_index, cfg_data     in
//
// Takes one sample pair per cycle while the queue is not full. A plane
// result passes from the accepted last pair through the queue write and
// the square stage, then accumulates into the result register. Reset
// clears position, plane and sum and loads 1920 x 1080, 4:2:0. The result
// register stalls only the last word of a plane; the four-word queue then
// fills before sample_ready drops.
// ----------------------------------------------------------------------------
module yuv_plane_ssd_accumulator #(
    parameter int MAX_WIDTH   = yuvssd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = yuvssd_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = yuvssd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [yuvssd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yuvssd_pkg::CFG_W-1:0]      cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic [SAMPLE_BITS-1:0]            ref_sample,
    input  logic [SAMPLE_BITS-1:0]            test_sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [yuvssd_pkg::PLANE_W-1:0]    plane,
    output logic [yuvssd_pkg::SSD_W-1:0]      plane_ssd,
    output logic                              frame_done
);

    localparam int CTRL_W = $bits(yuvssd_pkg::item_ctrl_t);
    localparam int Q_W    = SAMPLE_BITS + CTRL_W;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [SAMPLE_BITS-1:0] push_diff;
    yuvssd_pkg::item_ctrl_t push_ctrl;
    logic [Q_W-1:0]         pop_word;
    logic [SAMPLE_BITS-1:0] pop_diff;
    yuvssd_pkg::item_ctrl_t pop_ctrl;

    yuvssd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .ref_sample   (ref_sample),
        .test_sample  (test_sample),
        .q_push       (q_push),
        .q_diff       (push_diff),
        .q_ctrl       (push_ctrl),
        .q_full       (q_full)
    );

    yuvssd_fifo #(
        .WIDTH (Q_W),
        .DEPTH (yuvssd_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({push_diff, push_ctrl}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (pop_word),
        .empty (q_empty)
    );

    // Split the queue word back into difference and tag
    assign pop_diff = pop_word[Q_W-1:CTRL_W];
    assign pop_ctrl = yuvssd_pkg::item_ctrl_t'(pop_word[CTRL_W-1:0]);

    yuvssd_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_diff       (pop_diff),
        .q_ctrl       (pop_ctrl),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .plane        (plane),
        .plane_ssd    (plane_ssd),
        .frame_done   (frame_done)
    );

endmodule

/* dv/tb_yuv_plane_ssd_accumulator.sv */
// ----------------------------------------------------------------------------
// tb_yuv_plane_ssd_accumulator
// Self-checking bench for the per-plane SSD accumulator. A shadow raster
// tracker and running sum predict each plane result as sample words are
// accepted. A monitor compares every result word in order, field by field.
// Named test tasks cover reset geometry, corner samples, degenerate and
// clamped sizes, mid-plane register writes, a long result stall and
// random frames, with bursty input and a patterned result stall.
// ----------------------------------------------------------------------------
module tb_yuv_plane_ssd_accumulator;

    localparam int SAMPLE_BITS  = yuvssd_pkg::SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int CNT_W        = 12;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 350;
    localparam int TIMEOUT      = 10_000_000;

    // Chroma code that the block treats as full size
    localparam logic [yuvssd_pkg::MODE_W-1:0]    MODE_RESERVED = 2'd3;
    // Register index that maps to nothing
    localparam logic [yuvssd_pkg::CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;

    typedef struct {
        logic [yuvssd_pkg::PLANE_W-1:0] plane_no;
        logic [CNT_W-1:0]               col;
        logic [CNT_W-1:0]               row;
    } raster_pos_t;

    typedef struct {
        logic [yuvssd_pkg::PLANE_W-1:0] plane;
        logic [yuvssd_pkg::SSD_W-1:0]   ssd;
        logic                           done;
    } plane_sum_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MASK} ready_style_t;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [yuvssd_pkg::CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [yuvssd_pkg::CFG_W-1:0]        cfg_data     = '0;
    logic                                sample_valid = 1'b0;
    logic                                sample_ready;
    logic [SAMPLE_BITS-1:0]              ref_sample   = '0;
    logic [SAMPLE_BITS-1:0]              test_sample  = '0;
    logic                                result_valid;
    logic                                result_ready = 1'b0;
    logic [yuvssd_pkg::PLANE_W-1:0]      plane;
    logic [yuvssd_pkg::SSD_W-1:0]        plane_ssd;
    logic                                frame_done;

    // Shadow registers and predicted state
    logic [yuvssd_pkg::CFG_W-1:0]  shadow_width  = yuvssd_pkg::FRAME_WIDTH_RST;
    logic [yuvssd_pkg::CFG_W-1:0]  shadow_height = yuvssd_pkg::FRAME_HEIGHT_RST;
    logic [yuvssd_pkg::MODE_W-1:0] shadow_mode   = yuvssd_pkg::YUV420;
    raster_pos_t                   cur_pos       = '{yuvssd_pkg::PLANE_Y, '0, '0};
    logic [yuvssd_pkg::SSD_W-1:0]  running_ssd   = '0;
    plane_sum_t                    pending_sums[$];

    int                     mismatch_count = 0;
    int                     sent_count     = 0;
    int                     burst_left     = 0;
    bit                     pace_gaps      = 1'b1;

    // Receiver stall control
    int                     hold_req_count = 0;
    int                     hold_seen      = 0;
    int                     hold_left      = 0;
    int                     style_left     = 0;
    ready_style_t           stall_style    = READY_ALWAYS;
    logic [7:0]             stall_mask     = 8'hff;
    logic [2:0]             mask_phase     = '0;

    // Corner sample pairs for the directed frames
    int corner_ref [18] = '{
        0, 1023, 0, 1023, 512, 341, 682, 1, 1022,
        1023, 0, 100, 1023, 0, 7, 900, 256, 1023};
    int corner_test [18] = '{
        0, 0, 1023, 1023, 511, 682, 341, 0, 1023,
        1022, 1, 100, 1023, 1023, 8, 33, 768, 0};

    yuv_plane_ssd_accumulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .ref_sample   (ref_sample),
        .test_sample  (test_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .plane        (plane),
        .plane_ssd    (plane_ssd),
        .frame_done   (frame_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance a raster position by one sample; return 1 when a plane closes
    function automatic bit step_raster(inout raster_pos_t p);
        logic [yuvssd_pkg::CFG_W-1:0] pw;
        logic [yuvssd_pkg::CFG_W-1:0] ph;
        bit                           closed;
        closed = 1'b0;
        pw = (shadow_width > yuvssd_pkg::MAX_WIDTH_DEF)
           ? yuvssd_pkg::CFG_W'(yuvssd_pkg::MAX_WIDTH_DEF) : shadow_width;
        ph = (shadow_height > yuvssd_pkg::MAX_HEIGHT_DEF)
           ? yuvssd_pkg::CFG_W'(yuvssd_pkg::MAX_HEIGHT_DEF) : shadow_height;
        if (p.plane_no != yuvssd_pkg::PLANE_Y)
        begin
            if (shadow_mode == yuvssd_pkg::YUV420)
            begin
                pw = pw >> 1;
                ph = ph >> 1;
            end
            else if (shadow_mode == yuvssd_pkg::YUV422)
            begin
                pw = pw >> 1;
            end
        end
        if (pw == '0)
            pw = yuvssd_pkg::CFG_W'(1);
        if (ph == '0)
            ph = yuvssd_pkg::CFG_W'(1);
        p.col = p.col + CNT_W'(1);
        if (p.col == '0 || {1'b0, p.col} >= pw)
        begin
            p.col = '0;
            p.row = p.row + CNT_W'(1);
            if (p.row == '0 || {1'b0, p.row} >= ph)
            begin
                p.row      = '0;
                p.plane_no = (p.plane_no >= yuvssd_pkg::PLANE_V)
                           ? yuvssd_pkg::PLANE_Y
                           : p.plane_no + yuvssd_pkg::PLANE_W'(1);
                closed     = 1'b1;
            end
        end
        return closed;
    endfunction

    // Add one pair to the plane sum and queue the plane result when it closes
    function automatic void accumulate_pair(input logic [SAMPLE_BITS-1:0] r,
                                            input logic [SAMPLE_BITS-1:0] t);
        logic [SAMPLE_BITS-1:0]         diff;
        logic [yuvssd_pkg::PLANE_W-1:0] was_plane;
        plane_sum_t                     sum_word;
        diff        = (r >= t) ? r - t : t - r;
        running_ssd = running_ssd
                    + yuvssd_pkg::SSD_W'(diff) * yuvssd_pkg::SSD_W'(diff);
        was_plane   = cur_pos.plane_no;
        if (step_raster(cur_pos))
        begin
            sum_word.plane = was_plane;
            sum_word.ssd   = running_ssd;
            sum_word.done  = (was_plane >= yuvssd_pkg::PLANE_V);
            pending_sums.push_back(sum_word);
            running_ssd = '0;
        end
    endfunction

    // Count the samples still needed to close the current frame
    function automatic int frame_items_left();
        raster_pos_t                    probe;
        logic [yuvssd_pkg::PLANE_W-1:0] was_plane;
        int                             count;
        bit                             closed;
        probe  = cur_pos;
        count  = 0;
        closed = 1'b0;
        while (!closed)
        begin
            was_plane = probe.plane_no;
            count++;
            if (step_raster(probe) && was_plane == yuvssd_pkg::PLANE_V)
                closed = 1'b1;
        end
        return count;
    endfunction

    function automatic logic [yuvssd_pkg::CFG_W-1:0] pick_dim(input int typical_max);
        case ($urandom_range(0, 15))
            0:       return yuvssd_pkg::CFG_W'($urandom_range(0, 1));
            1:       return yuvssd_pkg::CFG_W'($urandom_range(typical_max + 1,
                                                             typical_max + 6));
            default: return yuvssd_pkg::CFG_W'($urandom_range(2, typical_max));
        endcase
    endfunction

    function automatic void pick_pair(output logic [SAMPLE_BITS-1:0] r,
                                      output logic [SAMPLE_BITS-1:0] t);
        r = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        case ($urandom_range(0, 5))
            0: t = r;
            1:
            begin
                r = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
                t = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
            end
            2: t = r ^ (SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1));
            default: t = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Check result words and track config and sample words
    always @(posedge clk)
    begin
        plane_sum_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    yuvssd_pkg::REG_FRAME_WIDTH:  shadow_width  = cfg_data;
                    yuvssd_pkg::REG_FRAME_HEIGHT: shadow_height = cfg_data;
                    yuvssd_pkg::REG_CHROMA_MODE:
                        shadow_mode = cfg_data[yuvssd_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    report_mismatch($sformatf("result word with none pending, plane %0d",
                                              plane));
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (plane !== want.plane)
                        report_mismatch($sformatf("plane %0d, want %0d", plane, want.plane));
                    if (plane_ssd !== want.ssd)
                        report_mismatch($sformatf("plane_ssd %0d, want %0d (plane %0d)",
                                                  plane_ssd, want.ssd, want.plane));
                    if (frame_done !== want.done)
                        report_mismatch($sformatf("frame_done %0b, want %0b (plane %0d)",
                                                  frame_done, want.done, want.plane));
                end
            end
            if (sample_valid && sample_ready)
                accumulate_pair(ref_sample, test_sample);
        end
    end

    // Stall the result side on a changing pattern; hold off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_seen != hold_req_count)
        begin
            hold_seen = hold_req_count;
            hold_left = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = ready_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(20, 200);
                stall_mask  = 8'($urandom) | 8'h01;
            end
            style_left = style_left - 1;
            mask_phase = mask_phase + 1'b1;
            case (stall_style)
                READY_ALWAYS: result_ready <= 1'b1;
                READY_COIN:   result_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:      result_ready <= stall_mask[mask_phase];
            endcase
        end
    end

    // Offer one sample word and hold it until accepted; open a gap between bursts
    task automatic send_pair(input logic [SAMPLE_BITS-1:0] r,
                             input logic [SAMPLE_BITS-1:0] t);
        sample_valid <= 1'b1;
        ref_sample   <= r;
        test_sample  <= t;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        sent_count++;
        if (pace_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                begin
                    sample_valid <= 1'b0;
                    repeat ($urandom_range(1, 7))
                        @(posedge clk);
                end
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_items(input int n);
        logic [SAMPLE_BITS-1:0] r;
        logic [SAMPLE_BITS-1:0] t;
        repeat (n)
        begin
            pick_pair(r, t);
            send_pair(r, t);
        end
    endtask

    task automatic finish_frame();
        send_items(frame_items_left());
    endtask

    // Stop sending and wait until every pending result word has come back
    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [yuvssd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [yuvssd_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [yuvssd_pkg::CFG_W-1:0] w,
                                input logic [yuvssd_pkg::CFG_W-1:0] h,
                                input logic [yuvssd_pkg::MODE_W-1:0] m);
        drain();
        write_reg(yuvssd_pkg::REG_FRAME_WIDTH, w);
        write_reg(yuvssd_pkg::REG_FRAME_HEIGHT, h);
        write_reg(yuvssd_pkg::REG_CHROMA_MODE, m);
    endtask

    // Start under reset geometry, then shrink it mid-plane and keep 4:2:0
    task automatic test_reset_defaults();
        send_items(3);
        drain();
        write_reg(yuvssd_pkg::REG_FRAME_WIDTH, 13'd8);
        write_reg(yuvssd_pkg::REG_FRAME_HEIGHT, 13'd4);
        finish_frame();
    endtask

    // Corner sample values over two tiny frames with odd sizes
    task automatic test_corner_samples();
        set_geometry(13'd3, 13'd2, yuvssd_pkg::YUV420);
        for (int i = 0; i < 8; i++)
            send_pair(SAMPLE_BITS'(corner_ref[i]), SAMPLE_BITS'(corner_test[i]));
        drain();
        write_reg(yuvssd_pkg::REG_CHROMA_MODE, yuvssd_pkg::YUV422);
        for (int i = 8; i < 18; i++)
            send_pair(SAMPLE_BITS'(corner_ref[i]), SAMPLE_BITS'(corner_test[i]));
    endtask

    // Zero and one sizes, the reserved chroma code and the unmapped index
    task automatic test_degenerate_sizes();
        set_geometry(13'd0, 13'd1, MODE_RESERVED);
        finish_frame();
        set_geometry(13'd1, 13'd0, yuvssd_pkg::YUV420);
        finish_frame();
        drain();
        write_reg(REG_UNUSED, yuvssd_pkg::CFG_W'($urandom_range(0, 8191)));
        set_geometry(13'd2, 13'd3, yuvssd_pkg::YUV422);
        finish_frame();
    endtask

    // Shrink width and height past the counters, then switch mode inside U
    task automatic test_mid_plane_resize();
        set_geometry(13'd20, 13'd6, yuvssd_pkg::YUV444);
        send_items(13);
        drain();
        write_reg(yuvssd_pkg::REG_FRAME_WIDTH, 13'd5);
        send_items(7);
        drain();
        write_reg(yuvssd_pkg::REG_FRAME_HEIGHT, 13'd2);
        finish_frame();
        set_geometry(13'd8, 13'd8, yuvssd_pkg::YUV420);
        send_items(67);
        drain();
        write_reg(yuvssd_pkg::REG_CHROMA_MODE, yuvssd_pkg::YUV444);
        finish_frame();
    endtask

    // Oversized width, then oversized height, each cut short mid-plane
    task automatic test_max_dims();
        set_geometry(13'd8191, 13'd1, yuvssd_pkg::YUV444);
        send_items(40);
        drain();
        write_reg(yuvssd_pkg::REG_FRAME_WIDTH, 13'd6);
        finish_frame();
        set_geometry(13'd0, 13'd8191, yuvssd_pkg::YUV420);
        send_items(40);
        drain();
        write_reg(yuvssd_pkg::REG_FRAME_HEIGHT, 13'd3);
        finish_frame();
    endtask

    // Hold the result side while one-sample planes pour in back to back
    task automatic test_backpressure();
        set_geometry(13'd1, 13'd1, yuvssd_pkg::YUV444);
        pace_gaps = 1'b0;
        hold_req_count++;
        send_items(40);
        pace_gaps = 1'b1;
        drain();
    endtask

    // Random small frames, some with a register write partway through
    task automatic test_random_frames();
        int start_count;
        int left;
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS)
        begin
            set_geometry(pick_dim(12), pick_dim(8),
                         yuvssd_pkg::MODE_W'($urandom_range(0, 3)));
            left = frame_items_left();
            if ($urandom_range(0, 3) == 0 && left > 2)
            begin
                send_items($urandom_range(1, left - 1));
                drain();
                case ($urandom_range(0, 2))
                    0:       write_reg(yuvssd_pkg::REG_FRAME_WIDTH, pick_dim(12));
                    1:       write_reg(yuvssd_pkg::REG_FRAME_HEIGHT, pick_dim(8));
                    default: write_reg(yuvssd_pkg::REG_CHROMA_MODE,
                                       yuvssd_pkg::MODE_W'($urandom_range(0, 3)));
                endcase
            end
            finish_frame();
        end
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_corner_samples();
        test_degenerate_sizes();
        test_mid_plane_resize();
        test_max_dims();
        test_backpressure();
        test_random_frames();
        drain();
        if (mismatch_count == 0)
            $display("yuv_plane_ssd_accumulator test passed");
        else
            $display("yuv_plane_ssd_accumulator test failed");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #(TIMEOUT);
        $display("yuv_plane_ssd_accumulator test failed");
        $finish;
    end

endmodule
